// ===== hdl/sadf_pkg.sv =====
package sadf_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = SLOT_W + 1;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [1:0] {
        MODE_RESERVE  = 2'd0,
        MODE_ALLOCATE = 2'd1,
        MODE_MARK     = 2'd2,
        MODE_SWEEP    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_FREE  = 2'd1,
        STAT_PENDING  = 2'd2,
        STAT_NOT_LIVE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SS_FREE      = 2'd0,
        SS_RESERVED  = 2'd1,
        SS_ALLOCATED = 2'd2,
        SS_PENDING   = 2'd3
    } t_slot_st;

    typedef struct packed {
        t_mode mode;
        t_slot slot;
    } t_cmd;

    typedef struct packed {
        t_slot   granted_slot;
        t_status status;
        t_cnt    freed_count;
        t_cnt    free_count;
        t_cnt    live_count;
    } t_result;

    // write request into the slot state table
    typedef struct packed {
        logic     en;
        t_slot    addr;
        t_slot_st data;
    } t_st_wr;

endpackage

// ===== hdl/sadf_state_mem.sv =====
module sadf_state_mem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sadf_pkg::t_slot    i_rd_addr,
    output sadf_pkg::t_slot_st o_rd_state,
    input  sadf_pkg::t_st_wr   i_wr
);
    import sadf_pkg::*;

    t_slot_st             r_mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] r_vld;
    t_slot_st             r_rd_data;
    logic                 r_rd_vld;

    // valid bits: an entry never written reads as free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[i_rd_addr];
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_rd_state = r_rd_vld ? r_rd_data : SS_FREE;

endmodule

// ===== hdl/slot_allocator_deferred_free_core.sv =====
// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+---------------------------
// command   | in        | start high, busy low     | i_cmd (mode, slot)
// result    | out       | o_done, one cycle        | o_result (granted, status,
//           |           |                          |   freed, free, live counts)
// capacity  | in        | i_cfg_we                 | i_cfg_wdata (slot_capacity)
//
// Reserve, allocate and mark read a memory (free FIFO or slot state table),
// then update and register the result. A sweep walks the live entries: per
// entry, read the allocation list, read the slot state, then free or compact.
// Once the core is idle, raising the capacity pushes one new free index per
// cycle; busy stays high until all are pushed. Reset is synchronous, active
// low; the slot state table clears at once through valid bits. The receiver
// cannot stall: each result beat is shown for exactly one cycle.
module slot_allocator_deferred_free_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  sadf_pkg::t_cmd    i_cmd,
    output logic              o_done,
    output sadf_pkg::t_result o_result,
    input  logic              i_cfg_we,
    input  sadf_pkg::t_cnt    i_cfg_wdata
);
    import sadf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RES,
        S_UPD,
        S_SW_ADDR,
        S_SW_STATE,
        S_SW_DEC
    } t_state;

    localparam t_cnt MAX_CNT = CNT_W'(MAX_SLOTS);

    // control and datapath registers
    t_state  r_state, n_state;
    t_cmd    r_cmd, n_cmd;
    t_slot   r_free_head, n_free_head;
    t_cnt    r_free_tally, n_free_tally;
    t_cnt    r_live_tally, n_live_tally;
    t_cnt    r_grown, n_grown;
    t_cnt    r_target, n_target;
    t_cnt    r_i, n_i;
    t_cnt    r_kept, n_kept;
    t_cnt    r_freed, n_freed;
    t_slot   r_sw_idx, n_sw_idx;
    logic    r_done, n_done;
    t_result r_result, n_result;

    // memories: free index ring and allocation-order list
    t_slot   r_fifo [MAX_SLOTS];
    t_slot   r_ord [MAX_SLOTS];
    t_slot   r_fifo_rd;
    t_slot   r_ord_rd;

    logic    fifo_we;
    t_slot   fifo_wa;
    t_slot   fifo_wd;
    logic    ord_we;
    t_slot   ord_wa;
    t_slot   ord_wd;

    t_st_wr   st_wr;
    t_slot    st_rd_addr;
    t_slot_st st_rd;

    logic    fin;
    t_slot   res_granted;
    t_status res_status;
    t_cnt    cfg_sat;

    sadf_state_mem u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (st_rd_addr),
        .o_rd_state (st_rd),
        .i_wr       (st_wr)
    );

    assign busy     = (r_state != S_IDLE) || (r_grown < r_target);
    assign o_done   = r_done;
    assign o_result = r_result;

    // the ring depth is a power of two, so the tail wraps by truncation
    assign fifo_wa = r_free_head + r_free_tally[SLOT_W-1:0];

    // slot state read address: command slot at accept, list entry during a sweep
    always_comb begin
        unique case (r_state)
            S_IDLE:     st_rd_addr = i_cmd.slot;
            S_SW_STATE: st_rd_addr = r_ord_rd;
            default:    st_rd_addr = r_sw_idx;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_free_head  = r_free_head;
        n_free_tally = r_free_tally;
        n_live_tally = r_live_tally;
        n_grown      = r_grown;
        n_target     = r_target;
        n_i          = r_i;
        n_kept       = r_kept;
        n_freed      = r_freed;
        n_sw_idx     = r_sw_idx;
        n_done       = 1'b0;
        n_result     = r_result;

        fifo_we     = 1'b0;
        fifo_wd     = r_grown[SLOT_W-1:0];
        ord_we      = 1'b0;
        ord_wa      = r_kept[SLOT_W-1:0];
        ord_wd      = r_sw_idx;
        st_wr       = '{en: 1'b0, addr: r_sw_idx, data: SS_FREE};
        fin         = 1'b0;
        res_granted = '0;
        res_status  = STAT_OK;

        // capacity only grows; clamp to the table depth
        cfg_sat = (i_cfg_wdata > MAX_CNT) ? MAX_CNT : i_cfg_wdata;
        if (i_cfg_we && (cfg_sat > r_target)) begin
            n_target = cfg_sat;
        end

        unique case (r_state)
            S_IDLE: begin
                if (r_grown < r_target) begin
                    // append the next newly covered index
                    if (r_free_tally < MAX_CNT) begin
                        fifo_we      = 1'b1;
                        n_free_tally = r_free_tally + 1'b1;
                    end
                    n_grown = r_grown + 1'b1;
                end else if (start) begin
                    n_cmd = i_cmd;
                    unique case (i_cmd.mode)
                        MODE_RESERVE:             n_state = S_RES;
                        MODE_ALLOCATE, MODE_MARK: n_state = S_UPD;
                        MODE_SWEEP: begin
                            n_i     = '0;
                            n_kept  = '0;
                            n_freed = '0;
                            n_state = S_SW_ADDR;
                        end
                        default:                  n_state = S_IDLE;
                    endcase
                end
            end

            S_RES: begin
                fin = 1'b1;
                if ((r_free_tally == '0) || (r_live_tally >= MAX_CNT)) begin
                    res_status = STAT_NO_FREE;
                end else begin
                    // pop the oldest free index, log it in reserve order
                    res_granted  = r_fifo_rd;
                    n_free_head  = r_free_head + 1'b1;
                    n_free_tally = r_free_tally - 1'b1;
                    n_live_tally = r_live_tally + 1'b1;
                    st_wr        = '{en: 1'b1, addr: r_fifo_rd, data: SS_RESERVED};
                    ord_we       = 1'b1;
                    ord_wa       = r_live_tally[SLOT_W-1:0];
                    ord_wd       = r_fifo_rd;
                end
            end

            S_UPD: begin
                fin = 1'b1;
                if (st_rd == SS_FREE) begin
                    res_status = STAT_NOT_LIVE;
                end else if (r_cmd.mode == MODE_ALLOCATE) begin
                    st_wr = '{en: 1'b1, addr: r_cmd.slot, data: SS_ALLOCATED};
                end else if (st_rd == SS_PENDING) begin
                    res_status = STAT_PENDING;
                end else begin
                    st_wr = '{en: 1'b1, addr: r_cmd.slot, data: SS_PENDING};
                end
            end

            S_SW_ADDR: begin
                if (r_i == r_live_tally) begin
                    fin          = 1'b1;
                    n_live_tally = r_kept;
                end else begin
                    n_state = S_SW_STATE;
                end
            end

            S_SW_STATE: begin
                n_sw_idx = r_ord_rd;
                n_state  = S_SW_DEC;
            end

            S_SW_DEC: begin
                if (st_rd == SS_PENDING) begin
                    st_wr = '{en: 1'b1, addr: r_sw_idx, data: SS_FREE};
                    if (r_free_tally < MAX_CNT) begin
                        fifo_we      = 1'b1;
                        fifo_wd      = r_sw_idx;
                        n_free_tally = r_free_tally + 1'b1;
                    end
                    n_freed = r_freed + 1'b1;
                end else begin
                    // compact survivors toward the head of the list
                    ord_we = 1'b1;
                    n_kept = r_kept + 1'b1;
                end
                n_i     = r_i + 1'b1;
                n_state = S_SW_ADDR;
            end

            default: n_state = S_IDLE;
        endcase

        if (fin) begin
            n_state                 = S_IDLE;
            n_done                  = 1'b1;
            n_result.granted_slot   = res_granted;
            n_result.status         = res_status;
            n_result.freed_count    = (r_cmd.mode == MODE_SWEEP) ? r_freed : '0;
            n_result.free_count     = n_free_tally;
            n_result.live_count     = n_live_tally;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_head  <= '0;
            r_free_tally <= '0;
            r_live_tally <= '0;
            r_grown      <= '0;
            r_target     <= '0;
            r_i          <= '0;
            r_kept       <= '0;
            r_freed      <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_head  <= n_free_head;
            r_free_tally <= n_free_tally;
            r_live_tally <= n_live_tally;
            r_grown      <= n_grown;
            r_target     <= n_target;
            r_i          <= n_i;
            r_kept       <= n_kept;
            r_freed      <= n_freed;
            r_done       <= n_done;
        end
        r_cmd    <= n_cmd;
        r_sw_idx <= n_sw_idx;
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        r_fifo_rd <= r_fifo[r_free_head];
        if (fifo_we) begin
            r_fifo[fifo_wa] <= fifo_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ord_rd <= r_ord[r_i[SLOT_W-1:0]];
        if (ord_we) begin
            r_ord[ord_wa] <= ord_wd;
        end
    end

    // once the block is idle, the free and live tallies never sum past the grown capacity
    a_tally_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
            (({1'b0, r_free_tally} + {1'b0, r_live_tally}) <= {1'b0, r_grown}))
        else $error("free plus live tally exceeds grown capacity");

    a_grow_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_grown <= r_target) && (r_target <= MAX_CNT))
        else $error("growth passed its target");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result beat lasted more than one cycle");

endmodule

// ===== sim/slot_allocator_deferred_free_core_tb.sv =====
`timescale 1ns / 1ps

module slot_allocator_deferred_free_core_tb;
    import sadf_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 1_000_000;
    // longest single command: a sweep over a full allocation list
    localparam int SWEEP_CYCLES = 2 + 3 * MAX_SLOTS;
    localparam int MAX_REPORTS  = 10;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_cmd    i_cmd = '0;
    logic    o_done;
    t_result o_result;
    logic    i_cfg_we = 1'b0;
    t_cnt    i_cfg_wdata = '0;

    // shadow copy of the allocator state
    t_slot    free_ring [MAX_SLOTS];
    t_slot    live_list [MAX_SLOTS];
    t_slot_st slot_st   [MAX_SLOTS];
    int       ring_head;
    int       free_total;
    int       live_total;
    int       grown_cap;

    t_result  pending_results [$];
    int       fail_cnt = 0;
    int       mismatch_cnt = 0;
    int       cycle_cnt = 0;
    int       sender_idle_pct = 0;

    // run statistics for the closing summary
    int       n_beats = 0;
    int       n_sweeps = 0;
    int       n_freed = 0;
    int       n_exhausted = 0;
    int       n_refused = 0;

    slot_allocator_deferred_free_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Abort a hung run; the limit covers thousands of full-list sweeps.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shadow allocator
    // ------------------------------------------------------------------
    function automatic void push_free(input t_slot idx);
        if (free_total < MAX_SLOTS) begin
            free_ring[(ring_head + free_total) % MAX_SLOTS] = idx;
            free_total++;
        end
    endfunction

    // Growing the capacity appends the newly covered indices in order;
    // a lower value leaves the state alone, a value past the table saturates.
    function automatic void grow_capacity(input t_cnt cap);
        int target;
        target = (int'(cap) > MAX_SLOTS) ? MAX_SLOTS : int'(cap);
        while (grown_cap < target) begin
            push_free(t_slot'(grown_cap));
            grown_cap++;
        end
    endfunction

    function automatic t_result apply_cmd(input t_cmd cmd);
        t_result res;
        int      kept;
        int      freed;
        t_slot   idx;
        res   = '0;
        kept  = 0;
        freed = 0;
        res.status = STAT_OK;
        case (cmd.mode)
            MODE_RESERVE: begin
                if (free_total == 0 || live_total >= MAX_SLOTS) begin
                    res.status = STAT_NO_FREE;
                    n_exhausted++;
                end else begin
                    idx = free_ring[ring_head];
                    ring_head = (ring_head + 1) % MAX_SLOTS;
                    free_total--;
                    slot_st[idx] = SS_RESERVED;
                    live_list[live_total] = idx;
                    live_total++;
                    res.granted_slot = idx;
                end
            end
            MODE_ALLOCATE: begin
                if (slot_st[cmd.slot] == SS_FREE) begin
                    res.status = STAT_NOT_LIVE;
                    n_refused++;
                end else begin
                    slot_st[cmd.slot] = SS_ALLOCATED;
                end
            end
            MODE_MARK: begin
                if (slot_st[cmd.slot] == SS_FREE) begin
                    res.status = STAT_NOT_LIVE;
                    n_refused++;
                end else if (slot_st[cmd.slot] == SS_PENDING) begin
                    res.status = STAT_PENDING;
                end else begin
                    slot_st[cmd.slot] = SS_PENDING;
                end
            end
            default: begin
                // free pending slots in list order, compact the survivors
                for (int i = 0; i < live_total; i++) begin
                    idx = live_list[i];
                    if (slot_st[idx] == SS_PENDING) begin
                        slot_st[idx] = SS_FREE;
                        push_free(idx);
                        freed++;
                    end else begin
                        live_list[kept] = idx;
                        kept++;
                    end
                end
                live_total = kept;
                n_sweeps++;
                n_freed += freed;
            end
        endcase
        res.freed_count = t_cnt'(freed);
        res.free_count  = t_cnt'(free_total);
        res.live_count  = t_cnt'(live_total);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every o_done beat must match the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                fail_cnt++;
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("[%0t] unexpected result beat: granted=%0d status=%0d "
                             , $time, o_result.granted_slot, o_result.status);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (o_result.granted_slot !== want.granted_slot ||
                    o_result.status       !== want.status       ||
                    o_result.freed_count  !== want.freed_count  ||
                    o_result.free_count   !== want.free_count   ||
                    o_result.live_count   !== want.live_count) begin
                    fail_cnt++;
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("[%0t] result mismatch", $time);
                        $display("  expected granted=%0d status=%0d freed=%0d free=%0d live=%0d",
                                 want.granted_slot, want.status, want.freed_count,
                                 want.free_count, want.live_count);
                        $display("  actual   granted=%0d status=%0d freed=%0d free=%0d live=%0d",
                                 o_result.granted_slot, o_result.status,
                                 o_result.freed_count, o_result.free_count,
                                 o_result.live_count);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Present one command beat, hold it until the core takes it, then
    // predict its result. Start is left high; the next call or a drain
    // decides at the following falling edge whether it drops.
    task automatic send_cmd(input t_mode mode, input t_slot slot);
        t_cmd    cmd;
        t_result pred;
        cmd.mode = mode;
        cmd.slot = slot;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= cmd;
        do @(posedge i_clk); while (busy);
        pred = apply_cmd(cmd);
        pending_results.insert(pending_results.size(), pred);
        n_beats++;
    endtask

    // Drop start, wait for every predicted beat, then for the core to go idle.
    task automatic drain(input int settle);
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Write the capacity register for one cycle; only called while idle.
    task automatic set_capacity(input t_cnt cap);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        grow_capacity(cap);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Pick a random command: mostly aimed at live slots so that allocate,
    // mark and sweep see real work, the rest random indices as noise.
    task automatic send_random_cmd();
        t_mode mode;
        t_slot slot;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            mode = MODE_RESERVE;
        else if (pick < 60)
            mode = MODE_ALLOCATE;
        else if (pick < 88)
            mode = MODE_MARK;
        else
            mode = MODE_SWEEP;
        if (live_total > 0 && $urandom_range(0, 99) < 80)
            slot = live_list[$urandom_range(0, live_total - 1)];
        else
            slot = t_slot'($urandom_range(0, MAX_SLOTS - 1));
        send_cmd(mode, slot);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Capacity zero: nothing to hand out, no slot is live.
    task automatic test_empty_pool();
        send_cmd(MODE_RESERVE, '0);
        send_cmd(MODE_ALLOCATE, t_slot'(MAX_SLOTS - 1));
        send_cmd(MODE_MARK, '0);
        send_cmd(MODE_SWEEP, t_slot'(MAX_SLOTS - 1));
        drain(4);
    endtask

    // Walk a few slots through every state transition, then shrink.
    task automatic test_slot_lifecycle();
        set_capacity(t_cnt'(4));
        for (int i = 0; i < 4; i++)
            send_cmd(MODE_RESERVE, '0);
        send_cmd(MODE_RESERVE, '0);                  // list exhausted
        send_cmd(MODE_ALLOCATE, t_slot'(0));
        send_cmd(MODE_ALLOCATE, t_slot'(0));         // already allocated
        send_cmd(MODE_MARK, t_slot'(0));
        send_cmd(MODE_MARK, t_slot'(0));             // second mark
        send_cmd(MODE_ALLOCATE, t_slot'(0));         // pending back to allocated
        send_cmd(MODE_MARK, t_slot'(0));
        send_cmd(MODE_MARK, t_slot'(1));             // mark straight from reserved
        send_cmd(MODE_ALLOCATE, t_slot'(5));         // beyond capacity, still free
        send_cmd(MODE_SWEEP, '0);
        send_cmd(MODE_RESERVE, '0);
        drain(4);
        set_capacity(t_cnt'(2));                     // shrink: no effect
        send_cmd(MODE_RESERVE, '0);
        send_cmd(MODE_RESERVE, '0);
        drain(4);
    endtask

    task automatic test_random_traffic(input int n_cmds, input t_cnt cap,
                                       input int idle_pct);
        set_capacity(cap);
        sender_idle_pct = idle_pct;
        for (int i = 0; i < n_cmds; i++)
            send_random_cmd();
        drain(4);
    endtask

    initial begin
        ring_head  = 0;
        free_total = 0;
        live_total = 0;
        grown_cap  = 0;
        foreach (slot_st[k]) slot_st[k] = SS_FREE;

        // hold reset, then release it on a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        sender_idle_pct = 7;
        test_empty_pool();
        test_slot_lifecycle();
        test_random_traffic(270, t_cnt'(20), 7);
        test_random_traffic(270, t_cnt'(MAX_SLOTS), 61);
        test_random_traffic(260, t_cnt'(127), 0);  // past the table: saturates

        drain(SWEEP_CYCLES);
        if (pending_results.size() != 0) begin
            fail_cnt++;
            $display("%0d predicted results never arrived", pending_results.size());
        end

        $display("Ran %0d command beats through capacities 0 to 127: %0d sweeps freed %0d slots,",
                 n_beats, n_sweeps, n_freed);
        $display("%0d reserves hit an empty list, %0d commands named a free slot; %0d mismatches",
                 n_exhausted, n_refused, mismatch_cnt);
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
